### hw/rtl/imp_pkg.sv
// Shared types and constants of the MTData2 frame parser.
package imp_pkg;

    localparam logic [1:0] KIND_VALUE    = 2'd0;
    localparam logic [1:0] KIND_ACCEPTED = 2'd1;
    localparam logic [1:0] KIND_CSUM_ERR = 2'd2;
    localparam logic [1:0] KIND_HDR_ERR  = 2'd3;

    localparam logic [1:0] CFG_PREAMBLE = 2'd0;
    localparam logic [1:0] CFG_BUS_ID   = 2'd1;
    localparam logic [1:0] CFG_MSG_ID   = 2'd2;

    localparam logic [7:0] PREAMBLE_RESET = 8'd250;
    localparam logic [7:0] BUS_ID_RESET   = 8'd255;
    localparam logic [7:0] MSG_ID_RESET   = 8'd54;

    localparam int NUM_QUANT = 16;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       take_byte;   // byte accepted this cycle
        logic       emit_start;  // checksum byte accepted: latch the frame outcome
        logic       emit_next;   // current result has been transferred
    } imp_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic       frame_end;   // the byte on s_rx_byte closes the frame
        logic       emit_done;   // the result on offer is the final one
    } imp_status_t;

endpackage

### hw/rtl/imu_mtdata2_frame_parser_core.sv
// Top level of the MTData2 frame parser.
// Takes one received byte per cycle, and each header or data byte produces
// no result. The checksum byte closes the frame: input then stalls while the
// results go out one per cycle while m_ready is high, from a single output
// register (one error result, or each updated quantity in ascending order
// followed by the frame-accepted result). Configuration registers
// are written through the cfg channel, which is always ready.
module imu_mtdata2_frame_parser_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [3:0]  m_quantity,
    output logic [63:0] m_value,
    output logic        m_last
);
    import imp_pkg::*;

    imp_cmd_t    cmd;
    imp_status_t status;

    assign cfg_ready = 1'b1;

    imp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    imp_datapath u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rx_byte   (s_rx_byte),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status),
        .kind      (m_kind),
        .quantity  (m_quantity),
        .value     (m_value),
        .last      (m_last)
    );

endmodule

### hw/rtl/imp_datapath.sv
// Datapath: frame tracking, sub-packet capture, shadow store and result selection.
module imp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [7:0]          rx_byte,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_data,
    input  imp_pkg::imp_cmd_t   cmd,
    output imp_pkg::imp_status_t status,
    output logic [1:0]          kind,
    output logic [3:0]          quantity,
    output logic [63:0]         value,
    output logic                last
);
    import imp_pkg::*;

    logic [7:0]  preamble_reg, bus_id_reg, msg_id_reg;
    logic [2:0]  fpos_reg, fpos_next;
    logic [7:0]  flen_reg, flen_next;
    logic [7:0]  sum_reg, sum_next;
    logic        hdr_reg, hdr_next;
    logic [1:0]  phase_reg, phase_next;
    logic [7:0]  group_reg, group_next;
    logic [7:0]  signal_reg, signal_next;
    logic [7:0]  remain_reg, remain_next;
    logic [4:0]  bidx_reg, bidx_next;
    logic [15:0] mask_reg, mask_next;
    logic [63:0] word_reg, word_next;
    logic [63:0] shadow_mem [NUM_QUANT];
    logic        sh_we;
    logic [3:0]  sh_addr;
    logic [63:0] sh_data;

    // Result sequencing
    logic [1:0]  okind_reg;
    logic [15:0] pend_reg, pend_next;
    logic [3:0]  oq_reg;
    logic [63:0] oval_reg;
    logic        olast_reg;
    logic [3:0]  first_q;
    logic        pend_any;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            preamble_reg <= PREAMBLE_RESET;
            bus_id_reg   <= BUS_ID_RESET;
            msg_id_reg   <= MSG_ID_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_PREAMBLE: preamble_reg <= cfg_data;
                CFG_BUS_ID:   bus_id_reg   <= cfg_data;
                CFG_MSG_ID:   msg_id_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign status.frame_end = (fpos_reg == 3'd4) && (flen_reg == 8'd0);

    // Capture decode for the current sub-packet
    logic [3:0] sig_hi;
    logic [3:0] cap_base;
    logic [1:0] cap_count;
    logic       cap_dbl, cap_known, cap_status;
    logic [4:0] cap_lim;
    logic [2:0] in_word;
    logic [1:0] word_no;

    always_comb begin
        sig_hi     = signal_reg[7:4];
        cap_base   = 4'd0;
        cap_count  = 2'd0;
        cap_dbl    = 1'b0;
        cap_known  = 1'b1;
        cap_status = 1'b0;
        if (group_reg == 8'h20 && sig_hi == 4'h3) begin
            cap_base = 4'd0; cap_count = 2'd3;
        end else if (group_reg == 8'h50 && sig_hi == 4'h4) begin
            cap_base = 4'd3; cap_count = 2'd2; cap_dbl = 1'b1;
        end else if (group_reg == 8'h50 && (sig_hi == 4'h1 || sig_hi == 4'h2)) begin
            cap_base = 4'd5; cap_count = 2'd1;
        end else if (group_reg == 8'h40 && (sig_hi == 4'h1 || sig_hi == 4'h2)) begin
            cap_base = 4'd6; cap_count = 2'd3;
        end else if (group_reg == 8'h80 && sig_hi == 4'h2) begin
            cap_base = 4'd9; cap_count = 2'd3;
        end else if (group_reg == 8'hD0 && sig_hi == 4'h1) begin
            cap_base = 4'd12; cap_count = 2'd3;
        end else if (group_reg == 8'hE0 && sig_hi == 4'h1) begin
            cap_status = 1'b1;
        end else begin
            cap_known = 1'b0;
        end
        cap_lim = cap_dbl ? {2'd0, cap_count, 1'b0} << 2 : {1'b0, cap_count, 2'b00};
        in_word = cap_dbl ? bidx_reg[2:0] : {1'b0, bidx_reg[1:0]};
        word_no = cap_dbl ? bidx_reg[4:3] : bidx_reg[3:2];
    end

    // Next state of the frame and sub-packet trackers
    always_comb begin
        fpos_next   = fpos_reg;
        flen_next   = flen_reg;
        sum_next    = sum_reg;
        hdr_next    = hdr_reg;
        phase_next  = phase_reg;
        group_next  = group_reg;
        signal_next = signal_reg;
        remain_next = remain_reg;
        bidx_next   = bidx_reg;
        mask_next   = mask_reg;
        word_next   = word_reg;
        sh_we       = 1'b0;
        sh_addr     = 4'd0;
        sh_data     = word_reg;
        if (cmd.take_byte) begin
            sum_next = sum_reg + rx_byte;
            unique case (fpos_reg)
                3'd0: begin
                    hdr_next   = (rx_byte == preamble_reg);
                    sum_next   = 8'd0;
                    mask_next  = 16'd0;
                    phase_next = 2'd0;
                    fpos_next  = 3'd1;
                end
                3'd1: begin
                    if (rx_byte != bus_id_reg) hdr_next = 1'b0;
                    fpos_next = 3'd2;
                end
                3'd2: begin
                    if (rx_byte != msg_id_reg) hdr_next = 1'b0;
                    fpos_next = 3'd3;
                end
                3'd3: begin
                    flen_next = rx_byte;
                    fpos_next = 3'd4;
                end
                default: begin
                    if (flen_reg == 8'd0) begin
                        fpos_next = 3'd0;
                    end else begin
                        flen_next = flen_reg - 8'd1;
                        if (hdr_reg) begin
                            unique case (phase_reg)
                                2'd0: begin group_next = rx_byte; phase_next = 2'd1; end
                                2'd1: begin signal_next = rx_byte; phase_next = 2'd2; end
                                2'd2: begin
                                    remain_next = rx_byte;
                                    bidx_next   = 5'd0;
                                    phase_next  = (rx_byte == 8'd0) ? 2'd0 : 2'd3;
                                end
                                default: begin
                                    if (cap_status) begin
                                        if (bidx_reg == 5'd0) begin
                                            sh_we     = 1'b1;
                                            sh_addr   = 4'd15;
                                            sh_data   = {63'd0, rx_byte[2]};
                                            mask_next[15] = 1'b1;
                                        end
                                    end else if (cap_known && bidx_reg < cap_lim) begin
                                        word_next = (in_word == 3'd0) ? {56'd0, rx_byte}
                                                  : {word_reg[55:0], rx_byte};
                                        if (in_word == (cap_dbl ? 3'd7 : 3'd3)) begin
                                            sh_we   = 1'b1;
                                            sh_addr = cap_base + {2'd0, word_no};
                                            sh_data = word_next;
                                            mask_next[sh_addr] = 1'b1;
                                        end
                                    end
                                    if (bidx_reg != 5'd31) bidx_next = bidx_reg + 5'd1;
                                    remain_next = remain_reg - 8'd1;
                                    if (remain_next == 8'd0) phase_next = 2'd0;
                                end
                            endcase
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fpos_reg   <= 3'd0;
            flen_reg   <= 8'd0;
            sum_reg    <= 8'd0;
            hdr_reg    <= 1'b0;
            phase_reg  <= 2'd0;
            group_reg  <= 8'd0;
            signal_reg <= 8'd0;
            remain_reg <= 8'd0;
            bidx_reg   <= 5'd0;
            mask_reg   <= 16'd0;
        end else begin
            fpos_reg   <= fpos_next;
            flen_reg   <= flen_next;
            sum_reg    <= sum_next;
            hdr_reg    <= hdr_next;
            phase_reg  <= phase_next;
            group_reg  <= group_next;
            signal_reg <= signal_next;
            remain_reg <= remain_next;
            bidx_reg   <= bidx_next;
            mask_reg   <= mask_next;
        end
        word_reg <= word_next;
    end

    // Shadow store of captured words
    always_ff @(posedge aclk) begin
        if (sh_we) shadow_mem[sh_addr] <= sh_data;
    end

    // Pick the lowest pending quantity
    always_comb begin
        first_q = 4'd0;
        for (int i = NUM_QUANT - 1; i >= 0; i--) begin
            if (pend_next[i]) first_q = 4'(i);
        end
        pend_any = |pend_next;
    end

    // Pending set of quantities still to report
    always_comb begin
        pend_next = pend_reg;
        if (cmd.emit_start) begin
            pend_next = (hdr_reg && sum_next == 8'd0) ? mask_reg : 16'd0;
        end else if (cmd.emit_next) begin
            pend_next = pend_reg & ~(16'd1 << oq_reg);
            if (okind_reg != KIND_VALUE) pend_next = 16'd0;
        end
    end

    // Result register: one result on offer at a time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg  <= 16'd0;
            okind_reg <= KIND_VALUE;
            olast_reg <= 1'b0;
            oq_reg    <= 4'd0;
        end else begin
            pend_reg <= pend_next;
            if (cmd.emit_start || cmd.emit_next) begin
                if (cmd.emit_start && !hdr_reg) begin
                    okind_reg <= KIND_HDR_ERR;
                    oq_reg    <= 4'd0;
                    olast_reg <= 1'b1;
                end else if (cmd.emit_start && sum_next != 8'd0) begin
                    okind_reg <= KIND_CSUM_ERR;
                    oq_reg    <= 4'd0;
                    olast_reg <= 1'b1;
                end else if (pend_any) begin
                    okind_reg <= KIND_VALUE;
                    oq_reg    <= first_q;
                    olast_reg <= 1'b0;
                end else begin
                    okind_reg <= KIND_ACCEPTED;
                    oq_reg    <= 4'd0;
                    olast_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit_start || cmd.emit_next) begin
            oval_reg <= shadow_mem[first_q];
        end
    end

    assign status.emit_done = olast_reg;
    assign kind     = okind_reg;
    assign quantity = oq_reg;
    assign value    = (okind_reg == KIND_VALUE) ? oval_reg : 64'd0;
    assign last     = olast_reg;

    // The checksum byte restarts the frame tracker
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_start |=> fpos_reg == 3'd0)
        else $error("frame tracker did not restart after the checksum byte");

    // A value result always names a quantity captured in this frame
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(okind_reg == KIND_VALUE && !olast_reg) |-> mask_reg[oq_reg])
        else $error("value result for a quantity not captured");

    // Error results end the sequence at once
    assert property (@(posedge aclk) disable iff (!aresetn)
        (okind_reg == KIND_CSUM_ERR || okind_reg == KIND_HDR_ERR) |-> olast_reg)
        else $error("error result not marked last");

endmodule

### hw/rtl/imp_ctrl.sv
// Controller: byte intake and result transfer sequencing.
module imp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  imp_pkg::imp_status_t status,
    output imp_pkg::imp_cmd_t    cmd
);
    import imp_pkg::*;

    localparam logic ST_RX   = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg, state_next;
    logic take, done;

    assign s_ready = (state_reg == ST_RX);
    assign m_valid = (state_reg == ST_EMIT);
    assign take    = s_valid && s_ready;
    assign done    = m_valid && m_ready;

    assign cmd.take_byte  = take;
    assign cmd.emit_start = take && status.frame_end;
    assign cmd.emit_next  = done && !status.emit_done;

    // Advance between byte intake and result output
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RX:   if (take && status.frame_end) state_next = ST_EMIT;
            ST_EMIT: if (done && status.emit_done) state_next = ST_RX;
            default: state_next = ST_RX;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= ST_RX;
        else          state_reg <= state_next;
    end

    // No byte is taken while results are on offer
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input and output active together");

    // The result sequence starts right after the checksum byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.emit_start |=> m_valid)
        else $error("no result after frame end");

    // The last transfer hands back to intake
    assert property (@(posedge aclk) disable iff (!aresetn)
        (done && status.emit_done) |=> s_ready)
        else $error("intake not resumed");

endmodule
